>>> hw/rtl/hsv2rgb_pkg.sv
`default_nettype none
package hsv2rgb_pkg;

  localparam int FIELD_W           = 16;
  localparam int CHANNEL_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF     = 16;
  localparam logic [FIELD_W-1:0] MAX_RESET = 16'd255;

  // hue sector: which two channels the ramp runs between
  typedef enum logic [1:0] {
    SEC_RG = 2'd0,
    SEC_GB = 2'd1,
    SEC_BR = 2'd2
  } sector_t;

endpackage
`default_nettype wire

>>> hw/rtl/hsv2rgb_if.sv
`default_nettype none
interface hsv2rgb_hsv_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::FIELD_W-1:0] hue;
  logic [hsv2rgb_pkg::FIELD_W-1:0] saturation;
  logic [hsv2rgb_pkg::FIELD_W-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::FIELD_W-1:0] red;
  logic [hsv2rgb_pkg::FIELD_W-1:0] green;
  logic [hsv2rgb_pkg::FIELD_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hsv_to_rgb_pixel.sv
`default_nettype none
// HSV to RGB pixel converter. Each item carries hue, saturation and value,
// all scaled so that the maximum register is full scale; the result item
// carries red, green and blue, truncated and clipped to maximum. The block
// takes one item per clock while the output is not held, and holds no
// state between items. It uses two restoring dividers of one quotient
// bit per stage: the first forms the hue ramp and saturation fractions
// (FRAC_BITS + 1 stages), the second normalizes each channel by the
// channel sum (CHANNEL_BITS + 2 stages). When the output is held, the
// whole pipeline freezes and nothing is lost. Write maximum only while
// the block is empty; a maximum of zero gives black.
module hsv_to_rgb_pixel #(
  parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF,
  parameter int FRAC_BITS    = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] cfg_wr_data,
  hsv2rgb_hsv_if.sink                          pix_in,
  hsv2rgb_rgb_if.source                        pix_out
);
  import hsv2rgb_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRAC_BITS;
  localparam int FW = FB + 1;

  logic [CB-1:0] maximum;
  logic          en;

  // front stage
  logic            fr_vld;
  logic [CB+FB-1:0] fr_fnum, fr_snum;
  logic [CB-1:0]   fr_div;
  sector_t         fr_sec;
  logic [CB-1:0]   fr_v;
  logic            fr_zero;

  // fraction dividers
  logic            fd_vld, sd_vld;
  logic [FW-1:0]   fd_q, sd_q;
  logic [1:0]      fd_side;
  logic [CB:0]     sd_side;

  // blend stages
  logic            bl_vld, bl_zero;
  logic [FB+1:0]   bl_total;
  logic [FB+CB+2:0] bl_nr, bl_ng, bl_nb;

  // normalizing dividers
  logic            rd_vld, gd_vld, bd_vld;
  logic [CB+1:0]   rd_q, gd_q, bd_q;
  logic            rd_z, gd_z, bd_z;

  // advance the whole pipeline unless a finished item is being held
  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      maximum <= MAX_RESET[CB-1:0];
    end else if (cfg_wr_en) begin
      maximum <= cfg_wr_data[CB-1:0];
    end
  end

  hsv2rgb_front #(.CB(CB), .FB(FB)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (pix_in.valid),
    .hue        (pix_in.hue),
    .saturation (pix_in.saturation),
    .brightness (pix_in.brightness),
    .maximum    (maximum),
    .out_valid  (fr_vld),
    .f_dividend (fr_fnum),
    .s_dividend (fr_snum),
    .divisor    (fr_div),
    .sector     (fr_sec),
    .value      (fr_v),
    .zero       (fr_zero)
  );

  // ramp fraction f = d*ONE/maximum, carries the sector
  hsv2rgb_div #(.NW(CB+FB), .DW(CB), .QW(FW), .SW(2)) u_fdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_vld),
    .dividend  (fr_fnum),
    .divisor   (fr_div),
    .side_in   (fr_sec),
    .out_valid (fd_vld),
    .quot      (fd_q),
    .side_out  (fd_side)
  );

  // saturation fraction s = sat*ONE/maximum, carries value and zero flag
  hsv2rgb_div #(.NW(CB+FB), .DW(CB), .QW(FW), .SW(CB+1)) u_sdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_vld),
    .dividend  (fr_snum),
    .divisor   (fr_div),
    .side_in   ({fr_zero, fr_v}),
    .out_valid (sd_vld),
    .quot      (sd_q),
    .side_out  (sd_side)
  );

  hsv2rgb_blend #(.CB(CB), .FB(FB)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fd_vld & sd_vld),
    .f         (fd_q),
    .s         (sd_q),
    .sector    (sector_t'(fd_side)),
    .value     (sd_side[CB-1:0]),
    .zero_in   (sd_side[CB]),
    .out_valid (bl_vld),
    .total     (bl_total),
    .num_r     (bl_nr),
    .num_g     (bl_ng),
    .num_b     (bl_nb),
    .zero_out  (bl_zero)
  );

  // channel * 3v / sum; quotient stays below 4 * 2^CB since sum >= ONE - 2
  hsv2rgb_div #(.NW(FB+CB+3), .DW(FB+2), .QW(CB+2), .SW(1)) u_rdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (bl_vld),
    .dividend  (bl_nr),
    .divisor   (bl_total),
    .side_in   (bl_zero),
    .out_valid (rd_vld),
    .quot      (rd_q),
    .side_out  (rd_z)
  );

  hsv2rgb_div #(.NW(FB+CB+3), .DW(FB+2), .QW(CB+2), .SW(1)) u_gdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (bl_vld),
    .dividend  (bl_ng),
    .divisor   (bl_total),
    .side_in   (bl_zero),
    .out_valid (gd_vld),
    .quot      (gd_q),
    .side_out  (gd_z)
  );

  hsv2rgb_div #(.NW(FB+CB+3), .DW(FB+2), .QW(CB+2), .SW(1)) u_bdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (bl_vld),
    .dividend  (bl_nb),
    .divisor   (bl_total),
    .side_in   (bl_zero),
    .out_valid (bd_vld),
    .quot      (bd_q),
    .side_out  (bd_z)
  );

  // output register: clip at maximum, force black for a zero maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (en) begin
      pix_out.valid <= rd_vld & gd_vld & bd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out.red   <= rd_z ? '0 : FIELD_W'((rd_q > {2'b00, maximum}) ? maximum : rd_q[CB-1:0]);
      pix_out.green <= gd_z ? '0 : FIELD_W'((gd_q > {2'b00, maximum}) ? maximum : gd_q[CB-1:0]);
      pix_out.blue  <= bd_z ? '0 : FIELD_W'((bd_q > {2'b00, maximum}) ? maximum : bd_q[CB-1:0]);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/hsv2rgb_front.sv
`default_nettype none
module hsv2rgb_front #(
  parameter int CB = 16,
  parameter int FB = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] hue,
  input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] saturation,
  input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] brightness,
  input  wire logic [CB-1:0]                   maximum,
  output logic                                 out_valid,
  output logic [CB+FB-1:0]                     f_dividend,
  output logic [CB+FB-1:0]                     s_dividend,
  output logic [CB-1:0]                        divisor,
  output hsv2rgb_pkg::sector_t                 sector,
  output logic [CB-1:0]                        value,
  output logic                                 zero
);
  import hsv2rgb_pkg::*;

  logic [CB-1:0]  h_c;
  logic [CB-1:0]  s_c;
  logic [CB+1:0]  h3;
  logic [CB+1:0]  m1;
  logic [CB+1:0]  m2;
  logic [CB+1:0]  d_wide;
  sector_t        sec_next;

  always_comb begin
    h_c = (hue[CB-1:0] > maximum) ? maximum : hue[CB-1:0];
    s_c = (saturation[CB-1:0] > maximum) ? maximum : saturation[CB-1:0];
    h3  = {2'b00, h_c} + {1'b0, h_c, 1'b0};
    m1  = {2'b00, maximum};
    m2  = {1'b0, maximum, 1'b0};
    // boundary hues take the earlier sector
    priority if (h3 <= m1) begin
      sec_next = SEC_RG;
      d_wide   = h3;
    end else if (h3 <= m2) begin
      sec_next = SEC_GB;
      d_wide   = h3 - m1;
    end else begin
      sec_next = SEC_BR;
      d_wide   = h3 - m2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_dividend <= {d_wide[CB-1:0], {FB{1'b0}}};
      s_dividend <= {s_c, {FB{1'b0}}};
      divisor    <= (maximum == '0) ? CB'(1) : maximum;
      sector     <= sec_next;
      value      <= brightness[CB-1:0];
      zero       <= (maximum == '0);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/hsv2rgb_div.sv
`default_nettype none
module hsv2rgb_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output logic [SW-1:0]      side_out
);

  // One quotient bit per stage. acc shifts the remaining dividend bits out
  // at the top while quotient bits shift in at the bottom.
  logic [QW-1:0] vld;
  logic [DW-1:0] rem     [QW];
  logic [QW-1:0] acc     [QW];
  logic [DW-1:0] dsr     [QW];
  logic [SW-1:0] side    [QW];

  logic [DW-1:0] rem_in  [QW];
  logic [QW-1:0] acc_in  [QW];
  logic [DW-1:0] dsr_in  [QW];
  logic [SW-1:0] side_a  [QW];
  logic [DW:0]   r2      [QW];
  logic [DW:0]   diff    [QW];
  logic [QW-1:0] ge;

  always_comb begin
    rem_in[0] = DW'(dividend[NW-1:QW]);
    acc_in[0] = dividend[QW-1:0];
    dsr_in[0] = divisor;
    side_a[0] = side_in;
    for (int k = 1; k < QW; k++) begin
      rem_in[k] = rem[k-1];
      acc_in[k] = acc[k-1];
      dsr_in[k] = dsr[k-1];
      side_a[k] = side[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      r2[k]   = {rem_in[k], acc_in[k][QW-1]};
      diff[k] = r2[k] - {1'b0, dsr_in[k]};
      ge[k]   = (r2[k] >= {1'b0, dsr_in[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k]  <= ge[k] ? diff[k][DW-1:0] : r2[k][DW-1:0];
        acc[k]  <= {acc_in[k][QW-2:0], ge[k]};
        dsr[k]  <= dsr_in[k];
        side[k] <= side_a[k];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = acc[QW-1];
  assign side_out  = side[QW-1];

endmodule
`default_nettype wire

>>> hw/rtl/hsv2rgb_blend.sv
`default_nettype none
module hsv2rgb_blend #(
  parameter int CB = 16,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [FB:0]          f,
  input  wire logic [FB:0]          s,
  input  wire hsv2rgb_pkg::sector_t sector,
  input  wire logic [CB-1:0]        value,
  input  wire logic                 zero_in,
  output logic                      out_valid,
  output logic [FB+1:0]             total,
  output logic [FB+CB+2:0]          num_r,
  output logic [FB+CB+2:0]          num_g,
  output logic [FB+CB+2:0]          num_b,
  output logic                      zero_out
);
  import hsv2rgb_pkg::*;

  localparam int FW = FB + 1;
  localparam int PW = FB + CB + 3;
  localparam logic [FW-1:0] ONE = FW'(1) << FB;

  logic [FW-1:0]   cr, cg, cb;

  logic            b_vld, b_zero;
  logic [2*FW-1:0] pr, pg, pb;
  logic [FW-1:0]   b_s;
  logic [CB-1:0]   b_v;

  logic            c_vld, c_zero;
  logic [FW-1:0]   c_r, c_g, c_b;
  logic [CB+1:0]   c_v3;
  logic [FW:0]     wr, wg, wb;
  logic [FW:0]     white;

  // ramp between the two channels of the sector
  always_comb begin
    unique case (sector)
      SEC_RG: begin
        cr = ONE - f; cg = f;       cb = '0;
      end
      SEC_GB: begin
        cr = '0;      cg = ONE - f; cb = f;
      end
      SEC_BR: begin
        cr = f;       cg = '0;      cb = ONE - f;
      end
      default: begin
        cr = '0;      cg = '0;      cb = '0;
      end
    endcase
  end

  // blend toward white: floor(s*c / ONE) + (ONE - s)
  always_comb begin
    white = (FW+1)'(ONE - b_s);
    wr    = pr[2*FW-1:FB] + white;
    wg    = pg[2*FW-1:FB] + white;
    wb    = pb[2*FW-1:FB] + white;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b_vld     <= in_valid;
      c_vld     <= b_vld;
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr     <= (2*FW)'(s) * (2*FW)'(cr);
      pg     <= (2*FW)'(s) * (2*FW)'(cg);
      pb     <= (2*FW)'(s) * (2*FW)'(cb);
      b_s    <= s;
      b_v    <= value;
      b_zero <= zero_in;

      c_r    <= wr[FW-1:0];
      c_g    <= wg[FW-1:0];
      c_b    <= wb[FW-1:0];
      c_v3   <= {2'b00, b_v} + {1'b0, b_v, 1'b0};
      c_zero <= b_zero;

      total    <= (FB+2)'(c_r) + (FB+2)'(c_g) + (FB+2)'(c_b);
      num_r    <= PW'(c_r) * PW'(c_v3);
      num_g    <= PW'(c_g) * PW'(c_v3);
      num_b    <= PW'(c_b) * PW'(c_v3);
      zero_out <= c_zero;
    end
  end

endmodule
`default_nettype wire

>>> test/hsv_to_rgb_pixel_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module hsv_to_rgb_pixel_tb;
  import hsv2rgb_pkg::*;

  localparam int CH_BITS   = CHANNEL_BITS_DEF;
  localparam int FR_BITS   = FRAC_BITS_DEF;
  localparam int LATENCY   = FR_BITS + CH_BITS + 8;
  localparam int STALL_MAX = 5000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [FIELD_W-1:0] cfg_wr_data = '0;

  hsv2rgb_hsv_if pix_in ();
  hsv2rgb_rgb_if pix_out ();

  hsv_to_rgb_pixel u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .pix_in(pix_in), .pix_out(pix_out)
  );

  always #4 clk = ~clk;

  // model copy of the maximum register
  logic [FIELD_W-1:0] full_scale = MAX_RESET;
  rgb_t expected_rgb[$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_output = 1'b0;

  // Compute the expected color for one pixel at the current full scale.
  function automatic rgb_t convert_pixel(logic [FIELD_W-1:0] h_in,
                                         logic [FIELD_W-1:0] s_in,
                                         logic [FIELD_W-1:0] v_in);
    logic [63:0] m, h, sat, v, r, g, b, f, s, t, h3, v3, one, q;
    logic [63:0] chan[3];
    rgb_t res;
    one = 64'd1 << FR_BITS;
    m = full_scale;
    h = h_in;
    sat = s_in;
    v = v_in;
    if (m == 0) return '0;
    if (h > m) h = m;
    if (sat > m) sat = m;
    h3 = 3 * h;
    // pick the sector; boundary hues fall in the earlier one
    if (h3 <= m) begin
      f = (h3 * one) / m;
      g = f; r = one - f; b = 0;
    end else if (h3 <= 2 * m) begin
      f = ((h3 - m) * one) / m;
      b = f; g = one - f; r = 0;
    end else begin
      f = ((h3 - 2 * m) * one) / m;
      r = f; b = one - f; g = 0;
    end
    // blend toward white by saturation
    s = (sat * one) / m;
    chan[0] = ((s * r) >> FR_BITS) + (one - s);
    chan[1] = ((s * g) >> FR_BITS) + (one - s);
    chan[2] = ((s * b) >> FR_BITS) + (one - s);
    t = chan[0] + chan[1] + chan[2];
    if (t == 0) t = 1;
    v3 = 3 * v;
    for (int i = 0; i < 3; i++) begin
      q = (chan[i] * v3) / t;
      chan[i] = (q > m) ? m : q;
    end
    res.red = chan[0][FIELD_W-1:0];
    res.green = chan[1][FIELD_W-1:0];
    res.blue = chan[2][FIELD_W-1:0];
    return res;
  endfunction

  // Offer one item, idling first at random; return once accepted.
  task automatic send_pixel(logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] s,
                            logic [FIELD_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.hue <= h;
    pix_in.saturation <= s;
    pix_in.brightness <= v;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    expected_rgb.push_back(convert_pixel(h, s, v));
  endtask

  // Drop valid after the last item of a sequence.
  task automatic stop_input();
    pix_in.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain everything in flight, then write the full scale.
  task automatic set_full_scale(logic [FIELD_W-1:0] value);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    full_scale = value;
  endtask

  function automatic logic [FIELD_W-1:0] rand_field();
    logic [FIELD_W-1:0] m;
    m = full_scale;
    case ($urandom_range(5))
      0: return FIELD_W'($urandom());
      1: return m;
      2: return FIELD_W'($urandom_range(3) + m);
      default: return FIELD_W'($urandom_range(m));
    endcase
  endfunction

  // Sector boundaries, extremes of every field and saturation above scale.
  task automatic test_directed();
    logic [FIELD_W-1:0] m;
    m = full_scale;
    send_pixel('0, m, m);
    send_pixel(FIELD_W'(m / 3), m, m);
    send_pixel(FIELD_W'(m / 3 + 1), m, m);
    send_pixel(FIELD_W'((2 * m) / 3), m, m);
    send_pixel(FIELD_W'((2 * m) / 3 + 1), m, m);
    send_pixel(m, m, m);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel('0, '0, '0);
    send_pixel(FIELD_W'(m / 2), '0, m);
    send_pixel(FIELD_W'(m / 6), FIELD_W'(m / 2), m);
    send_pixel(m, FIELD_W'(m + 1), 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    stop_input();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pixel(rand_field(), rand_field(), rand_field());
    stop_input();
  endtask

  // Hold the output long enough to fill the pipeline and block the input.
  task automatic test_backpressure();
    hold_output = 1'b1;
    fork
      repeat (LONG_HOLD) @(posedge clk);
      test_random(80);
    join_any
    hold_output = 1'b0;
    wait fork;
  endtask

  // Drive ready; idle at random or hold off when asked.
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (expected_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item r=%0d g=%0d b=%0d", pix_out.red, pix_out.green,
                   pix_out.blue);
      end else begin
        exp_rgb = expected_rgb.pop_front();
        if (pix_out.red !== exp_rgb.red || pix_out.green !== exp_rgb.green ||
            pix_out.blue !== exp_rgb.blue) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                     pix_out.red, pix_out.green, pix_out.blue);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves.
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pix_in.valid <= 1'b0;
    pix_in.hue <= '0;
    pix_in.saturation <= '0;
    pix_in.brightness <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset scale, sender idles 27 percent, receiver 62
    send_idle_pct = 27;
    recv_idle_pct = 62;
    test_directed();
    test_random(300);

    // scale of 3, roles swapped
    set_full_scale(3);
    send_idle_pct = 62;
    recv_idle_pct = 27;
    test_directed();
    test_random(250);

    // maximum scale, no idling
    set_full_scale(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_directed();
    test_random(300);
    test_backpressure();

    // scale of 1000, zero scale, then a mid value
    set_full_scale(1000);
    test_directed();
    test_random(250);
    set_full_scale(0);
    test_random(20);
    set_full_scale(16'h8001);
    test_random(250);

    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_rgb.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_if.sv
hw/rtl/hsv2rgb_front.sv
hw/rtl/hsv2rgb_div.sv
hw/rtl/hsv2rgb_blend.sv
hw/rtl/hsv_to_rgb_pixel.sv
test/hsv_to_rgb_pixel_tb.sv
